>>> hw/rtl/kteq_pkg.sv
// ----------------------------------------------------------------------------
// kteq_pkg
// Shared widths, defaults and control types of the keyed timer event queue.
// ----------------------------------------------------------------------------
package kteq_pkg;

    // default number of slots in the event table
    localparam int QUEUE_DEPTH_DEF = 16;

    // field widths
    localparam int KEY_W  = 16;
    localparam int TIME_W = 63;
    localparam int TAG_W  = 16;

    // stream data widths, whole bytes
    localparam int S_DATA_W = 96;   // event_key, event_time, action_tag, pad
    localparam int M_DATA_W = 96;   // fired_key, fired_tag, report_time, table_full

    // item kinds carried on s_tuser
    localparam logic FUNC_SCHEDULE = 1'b0;
    localparam logic FUNC_ADVANCE  = 1'b1;

    // commands from the controller to the datapath (single-cycle pulses)
    typedef struct packed {
        logic scan_start;   // restart the pass over all slots
        logic commit;       // apply a schedule item and load its ack
        logic fire;         // remove the earliest due entry and report it
        logic marker;       // move current time on and load the final marker
    } kteq_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;    // last slot of the pass compared this cycle
        logic is_adv;       // held item is an advance
        logic found;        // pass found an entry due before the advance time
        logic out_free;     // output register can take a beat
    } kteq_stat_t;

endpackage

>>> hw/rtl/kteq_ctrl.sv
// ----------------------------------------------------------------------------
// kteq_ctrl
// Sequencer of the event queue: accepts an item, runs slot passes and
// issues commit, fire and marker commands to the datapath.
// ----------------------------------------------------------------------------
module kteq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               in_ready,
    input  kteq_pkg::kteq_stat_t stat,
    output kteq_pkg::kteq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic                 in_ready_reg;
    kteq_pkg::kteq_cmd_t  cmd_reg;
    kteq_pkg::kteq_cmd_t  cmd_next;

    assign in_ready = in_ready_reg;
    assign cmd      = cmd_reg;

    // command pulses for the next cycle
    always_comb
    begin
        cmd_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_next.scan_start = s_tvalid && in_ready_reg;
            end
            ST_SCAN:
            begin
                cmd_next = '0;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    // fire one entry and look again, or close the item
                    cmd_next.commit     = !stat.is_adv;
                    cmd_next.fire       = stat.is_adv && stat.found;
                    cmd_next.scan_start = stat.is_adv && stat.found;
                    cmd_next.marker     = stat.is_adv && !stat.found;
                end
            end
            default:
            begin
                cmd_next = '0;
            end
        endcase
    end

    // state and registered command pulses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
            cmd_reg      <= '0;
        end
        else
        begin
            cmd_reg <= cmd_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && in_ready_reg)
                    begin
                        in_ready_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (stat.scan_done)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (stat.out_free)
                    begin
                        priority if (!stat.is_adv)
                        begin
                            in_ready_reg <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                        else if (stat.found)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            in_ready_reg <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // at most one result command per cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd_reg.commit, cmd_reg.fire, cmd_reg.marker}))
        else $error("kteq_ctrl: more than one result command");

    // every firing starts the next pass at once
    a_fire_rescan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg.fire |-> cmd_reg.scan_start)
        else $error("kteq_ctrl: fire without a new pass");

    // an accepted beat starts a pass and closes the input
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && in_ready_reg) |=> (cmd_reg.scan_start && !in_ready_reg))
        else $error("kteq_ctrl: accepted beat did not start a pass");

endmodule

>>> hw/rtl/kteq_dp.sv
// ----------------------------------------------------------------------------
// kteq_dp
// Datapath of the event queue: slot memory, valid bits, current time,
// the one-slot-per-cycle compare pass and the output register.
// ----------------------------------------------------------------------------
module kteq_dp
#(
    parameter int QUEUE_DEPTH = kteq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_load,
    input  logic                          item_func,
    input  logic [kteq_pkg::S_DATA_W-1:0] item_data,
    input  kteq_pkg::kteq_cmd_t           cmd,
    output kteq_pkg::kteq_stat_t          stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kteq_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    localparam int KEY_W  = kteq_pkg::KEY_W;
    localparam int TIME_W = kteq_pkg::TIME_W;
    localparam int TAG_W  = kteq_pkg::TAG_W;
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    // slot memory
    logic [KEY_W-1:0]  key_mem [QUEUE_DEPTH];
    logic [TIME_W-1:0] due_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]  tag_mem [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_reg;

    // held item
    logic              func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [TIME_W-1:0] cur_time_reg;

    // pass control and read data
    logic              scan_act_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [KEY_W-1:0]  rd_key_reg;
    logic [TIME_W-1:0] rd_due_reg;
    logic [TAG_W-1:0]  rd_tag_reg;

    // pass results
    logic              hit_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              best_found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [TIME_W-1:0] best_due_reg;
    logic [KEY_W-1:0]  best_key_reg;
    logic [TAG_W-1:0]  best_tag_reg;

    // output register
    logic              out_vld_reg;
    logic              out_fired_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic              out_full_reg;
    logic              out_last_reg;

    logic              cmp_valid;
    logic              key_hit;
    logic              due_early;
    logic              due_best;
    logic              scan_done;
    logic [IDX_W-1:0]  wr_idx;
    logic              wr_ok;
    logic [TIME_W-1:0] fire_time;
    logic [TIME_W-1:0] marker_time;

    // compare of the slot read last cycle
    assign cmp_valid = cmp_vld_reg && valid_reg[cmp_idx_reg];
    assign key_hit   = cmp_valid && (rd_key_reg == key_reg);
    assign due_early = cmp_valid && (rd_due_reg < time_reg);
    assign due_best  = !best_found_reg || (rd_due_reg < best_due_reg);
    assign scan_done = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);

    // slot chosen by a schedule item: key match first, then lowest free slot
    assign wr_ok  = hit_found_reg || free_found_reg;
    assign wr_idx = hit_found_reg ? hit_idx_reg : free_idx_reg;

    // running current time
    assign fire_time   = (best_due_reg > cur_time_reg) ? best_due_reg : cur_time_reg;
    assign marker_time = (time_reg > cur_time_reg) ? time_reg : cur_time_reg;

    assign stat.scan_done = scan_done;
    assign stat.is_adv    = (func_reg == kteq_pkg::FUNC_ADVANCE);
    assign stat.found     = best_found_reg;
    assign stat.out_free  = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_fired_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_full_reg, out_time_reg, out_tag_reg, out_key_reg};

    // item capture
    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            func_reg <= item_func;
            key_reg  <= item_data[KEY_W-1:0];
            time_reg <= item_data[KEY_W+TIME_W-1:KEY_W];
            tag_reg  <= item_data[KEY_W+TIME_W+TAG_W-1:KEY_W+TIME_W];
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_ok)
        begin
            key_mem[wr_idx] <= key_reg;
            due_mem[wr_idx] <= time_reg;
            tag_mem[wr_idx] <= tag_reg;
        end
        rd_key_reg <= key_mem[rd_idx_reg];
        rd_due_reg <= due_mem[rd_idx_reg];
        rd_tag_reg <= tag_mem[rd_idx_reg];
    end

    // valid bits and current time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            cur_time_reg <= '0;
        end
        else
        begin
            if (cmd.commit && wr_ok)
                valid_reg[wr_idx] <= 1'b1;
            if (cmd.fire)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                cur_time_reg            <= fire_time;
            end
            if (cmd.marker)
                cur_time_reg <= marker_time;
        end
    end

    // pass sequencing: read address, then compare in the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_act_reg <= 1'b0;
            rd_idx_reg   <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
        end
        else
        begin
            cmp_vld_reg <= scan_act_reg;
            cmp_idx_reg <= rd_idx_reg;
            if (cmd.scan_start)
            begin
                scan_act_reg <= 1'b1;
                rd_idx_reg   <= '0;
            end
            else if (scan_act_reg)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                if (rd_idx_reg == LAST_IDX)
                    scan_act_reg <= 1'b0;
            end
        end
    end

    // pass results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (cmp_vld_reg)
        begin
            if (key_hit && !hit_found_reg)
                hit_found_reg <= 1'b1;
            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                free_found_reg <= 1'b1;
            if (due_early && due_best)
                best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_vld_reg)
        begin
            if (key_hit && !hit_found_reg)
                hit_idx_reg <= cmp_idx_reg;
            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                free_idx_reg <= cmp_idx_reg;
            // strict compare keeps the lowest slot on equal due times
            if (due_early && due_best)
            begin
                best_idx_reg <= cmp_idx_reg;
                best_due_reg <= rd_due_reg;
                best_key_reg <= rd_key_reg;
                best_tag_reg <= rd_tag_reg;
            end
        end
    end

    // output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.commit || cmd.fire || cmd.marker)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    // output register: payload
    always_ff @(posedge clk)
    begin
        priority if (cmd.commit)
        begin
            out_fired_reg <= 1'b0;
            out_key_reg   <= '0;
            out_tag_reg   <= '0;
            out_time_reg  <= '0;
            out_full_reg  <= !wr_ok;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.fire)
        begin
            out_fired_reg <= 1'b1;
            out_key_reg   <= best_key_reg;
            out_tag_reg   <= best_tag_reg;
            out_time_reg  <= fire_time;
            out_full_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.marker)
        begin
            out_fired_reg <= 1'b0;
            out_key_reg   <= '0;
            out_tag_reg   <= '0;
            out_time_reg  <= marker_time;
            out_full_reg  <= 1'b0;
            out_last_reg  <= 1'b1;
        end
        else
        begin
            out_fired_reg <= out_fired_reg;
        end
    end

    // a result is only loaded into an empty output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.fire || cmd.marker) |-> !out_vld_reg)
        else $error("kteq_dp: result loaded over a waiting beat");

    // a firing always removes a live entry found by the pass
    a_fire_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> (best_found_reg && valid_reg[best_idx_reg]))
        else $error("kteq_dp: fire without a live entry");

    // reads of a pass are all issued before its last compare
    a_pass_order: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> !scan_act_reg)
        else $error("kteq_dp: pass ended with reads outstanding");

endmodule

>>> hw/rtl/keyed_timer_event_queue.sv
// ----------------------------------------------------------------------------
// keyed_timer_event_queue
// Timed event table keyed by identifier: schedule/replace and advance-time
// with earliest-first firing.
// ----------------------------------------------------------------------------
//  channel | dir | beat                | fields
//  s_*     | in  | one item            | tuser: func; tdata: event_key,
//          |     |                     |   event_time, action_tag
//  m_*     | out | one result          | tuser: fired; tdata: fired_key,
//          |     |                     |   fired_tag, report_time, table_full;
//          |     |                     |   tlast: last
//
// Every result needs a full pass over the slots through the single read port.
// Schedule gives one beat; advance one per firing plus the final marker. The
// next item is taken as the last result enters the output register. Reset
// clears all slots and current time at once; m_tready low holds the
// sequencer before its next result.
// ----------------------------------------------------------------------------
module keyed_timer_event_queue
#(
    parameter int QUEUE_DEPTH = kteq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kteq_pkg::S_DATA_W-1:0] s_tdata,   // event_key, event_time, action_tag
    input  logic                          s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kteq_pkg::M_DATA_W-1:0] m_tdata,   // fired_key, fired_tag, report_time,
                                                     // table_full
    output logic                          m_tuser,   // fired
    output logic                          m_tlast    // last
);

    kteq_pkg::kteq_cmd_t  cmd;
    kteq_pkg::kteq_stat_t stat;
    logic                 in_ready;
    logic                 in_beat;

    assign s_tready = in_ready;
    assign in_beat  = s_tvalid && in_ready;

    kteq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kteq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_load (in_beat),
        .item_func (s_tuser),
        .item_data (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
